// File: rtl/i2c_mts_pkg.sv
package i2c_mts_pkg;

    localparam int MAX_BYTES_DEF = 4;

    // transaction kinds
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_EVENT = 1'b1;

    // controller status codes
    localparam logic [7:0] ST_BUS_ERROR  = 8'h00;
    localparam logic [7:0] ST_START      = 8'h08;
    localparam logic [7:0] ST_RESTART    = 8'h10;
    localparam logic [7:0] ST_ADDR_ACK   = 8'h18;
    localparam logic [7:0] ST_ADDR_NACK  = 8'h20;
    localparam logic [7:0] ST_DATA_ACK   = 8'h28;
    localparam logic [7:0] ST_DATA_NACK  = 8'h30;
    localparam logic [7:0] ST_ARB_LOST   = 8'h38;
    localparam logic [7:0] ST_RADDR_ACK  = 8'h40;
    localparam logic [7:0] ST_RADDR_NACK = 8'h48;
    localparam logic [7:0] ST_RX_ACKED   = 8'h50;
    localparam logic [7:0] ST_RX_NACKED  = 8'h58;

    localparam logic [7:0] READ_BIT = 8'h01;

    // ack_control codes
    localparam logic [1:0] ACK_KEEP = 2'd0;
    localparam logic [1:0] ACK_NEXT = 2'd1;
    localparam logic [1:0] NACK_NEXT = 2'd2;

    // completion codes
    localparam logic [1:0] CMP_BUSY  = 2'd0;
    localparam logic [1:0] CMP_READ  = 2'd1;
    localparam logic [1:0] CMP_WRITE = 2'd2;

    typedef struct packed {
        logic        action;
        logic        read_mode;
        logic [7:0]  device_address;
        logic [7:0]  first_register;
        logic [2:0]  byte_count;
        logic [31:0] write_data;
        logic [7:0]  bus_status;
        logic [7:0]  received_byte;
    } t_in_item;

    typedef struct packed {
        logic        accepted;
        logic        send_start;
        logic        clear_start;
        logic        send_stop;
        logic        load_byte_valid;
        logic [7:0]  transmit_byte;
        logic [1:0]  ack_control;
        logic        clear_interrupt;
        logic [1:0]  completion;
        logic        error_flag;
        logic [7:0]  error_status;
        logic [31:0] read_data;
    } t_out_item;

endpackage

// File: rtl/i2c_mts_if.sv
interface i2c_mts_in_if
    import i2c_mts_pkg::*;
;
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface i2c_mts_out_if
    import i2c_mts_pkg::*;
;
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/i2c_mts_core.sv
module i2c_mts_core
    import i2c_mts_pkg::*;
#(
    parameter int MAX_BYTES = MAX_BYTES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_advance,
    input  t_in_item  i_item,
    output t_out_item o_result
);

    localparam logic [3:0] CNT_LIMIT = 4'(MAX_BYTES);
    localparam int PACK_N = (MAX_BYTES < 4) ? MAX_BYTES : 4;

    logic [7:0] r_slave, n_slave;
    logic [7:0] r_reg, n_reg;
    logic       r_is_read, n_is_read;
    logic [2:0] r_tc, n_tc;
    logic [7:0] r_buf [MAX_BYTES];
    logic [7:0] n_buf [MAX_BYTES];
    logic [2:0] r_ptr, n_ptr;
    logic       r_err, n_err;
    logic [7:0] r_err_code, n_err_code;

    always_comb begin
        logic [7:0]  tx_data;
        logic [2:0]  ptr_bump;
        logic        do_stop;
        logic        do_store;
        logic [7:0]  st;

        n_slave    = r_slave;
        n_reg      = r_reg;
        n_is_read  = r_is_read;
        n_tc       = r_tc;
        n_buf      = r_buf;
        n_ptr      = r_ptr;
        n_err      = r_err;
        n_err_code = r_err_code;
        o_result   = '0;
        do_stop    = 1'b0;
        do_store   = 1'b0;
        st         = i_item.bus_status;
        ptr_bump   = (r_ptr != 3'd7) ? r_ptr + 3'd1 : r_ptr;

        // data byte at the current pointer, zero past the buffer
        tx_data = 8'h00;
        for (int i = 0; i < MAX_BYTES; i++) begin
            if (r_ptr == 3'(i)) begin
                tx_data = r_buf[i];
            end
        end

        if (i_item.action == ACT_START) begin
            if ({1'b0, i_item.byte_count} <= CNT_LIMIT) begin
                n_err      = 1'b0;
                n_err_code = 8'h00;
                n_is_read  = i_item.read_mode;
                n_slave    = i_item.device_address;
                n_reg      = i_item.first_register;
                n_tc       = i_item.byte_count;
                if (!i_item.read_mode) begin
                    for (int i = 0; i < MAX_BYTES; i++) begin
                        if (3'(i) < i_item.byte_count) begin
                            n_buf[i] = 8'(i_item.write_data >> (8 * i));
                        end
                    end
                end
                o_result.accepted   = 1'b1;
                o_result.send_start = 1'b1;
            end
        end else begin
            case (st)
                ST_START: begin
                    n_ptr                    = 3'd0;
                    o_result.load_byte_valid = 1'b1;
                    o_result.transmit_byte   = r_slave;
                    o_result.clear_interrupt = 1'b1;
                end
                ST_RESTART: begin
                    o_result.load_byte_valid = 1'b1;
                    o_result.transmit_byte   = r_slave | READ_BIT;
                    o_result.clear_interrupt = 1'b1;
                end
                ST_ADDR_ACK: begin
                    o_result.clear_start = 1'b1;
                    if (r_tc == 3'd0) begin
                        do_stop = 1'b1;
                    end else begin
                        o_result.load_byte_valid = 1'b1;
                        o_result.transmit_byte   = r_reg;
                        o_result.clear_interrupt = 1'b1;
                    end
                end
                ST_DATA_ACK: begin
                    if (r_is_read) begin
                        o_result.send_start      = 1'b1;
                        o_result.clear_interrupt = 1'b1;
                    end else if (r_ptr >= r_tc) begin
                        do_stop = 1'b1;
                    end else begin
                        n_ptr                    = ptr_bump;
                        o_result.load_byte_valid = 1'b1;
                        o_result.transmit_byte   = tx_data;
                        o_result.clear_interrupt = 1'b1;
                    end
                end
                ST_RADDR_ACK: begin
                    o_result.clear_start     = 1'b1;
                    o_result.ack_control     = (r_tc > 3'd1) ? ACK_NEXT : NACK_NEXT;
                    o_result.clear_interrupt = 1'b1;
                end
                ST_RX_ACKED: begin
                    do_store = 1'b1;
                    n_ptr    = ptr_bump;
                    // NACK once the byte after this one is the last
                    o_result.ack_control =
                        (({1'b0, ptr_bump} + 4'd1) >= {1'b0, r_tc}) ? NACK_NEXT : ACK_NEXT;
                    o_result.clear_interrupt = 1'b1;
                end
                ST_RX_NACKED: begin
                    do_store = 1'b1;
                    n_ptr    = ptr_bump;
                    do_stop  = 1'b1;
                end
                ST_ARB_LOST: begin
                    n_err      = 1'b1;
                    n_err_code = st;
                    n_ptr      = 3'd0;
                end
                default: begin
                    n_err      = 1'b1;
                    n_err_code = st;
                    do_stop    = 1'b1;
                end
            endcase
        end

        if (do_store) begin
            for (int i = 0; i < MAX_BYTES; i++) begin
                if (r_ptr == 3'(i)) begin
                    n_buf[i] = i_item.received_byte;
                end
            end
        end

        if (do_stop) begin
            o_result.clear_start     = 1'b1;
            o_result.send_stop       = 1'b1;
            o_result.clear_interrupt = 1'b1;
            o_result.completion      = r_is_read ? CMP_READ : CMP_WRITE;
        end

        o_result.error_flag   = n_err;
        o_result.error_status = n_err_code;
        for (int i = 0; i < PACK_N; i++) begin
            o_result.read_data[8*i +: 8] = n_buf[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave    <= '0;
            r_reg      <= '0;
            r_is_read  <= 1'b0;
            r_tc       <= '0;
            r_ptr      <= '0;
            r_err      <= 1'b0;
            r_err_code <= '0;
            for (int i = 0; i < MAX_BYTES; i++) begin
                r_buf[i] <= '0;
            end
        end else if (i_advance) begin
            r_slave    <= n_slave;
            r_reg      <= n_reg;
            r_is_read  <= n_is_read;
            r_tc       <= n_tc;
            r_ptr      <= n_ptr;
            r_err      <= n_err;
            r_err_code <= n_err_code;
            r_buf      <= n_buf;
        end
    end

endmodule

// File: rtl/i2c_master_transfer_sequencer.sv
// I2C master register-transfer sequencer. Each input transaction is either a
// start (load a read or write transfer of up to MAX_BYTES bytes) or a bus
// status event from the I2C controller; every one gives exactly one result
// transaction carrying the controller requests, completion, error and the
// packed receive buffer. One transaction is accepted per clock while input ready is high;
// its result passes the input register, then the result register, before it is offered,
// and the sequencer state is updated in the same cycle as the result register.
// Input ready drops only while the result register is full and not taken.
module i2c_master_transfer_sequencer
    import i2c_mts_pkg::*;
#(
    parameter int MAX_BYTES = MAX_BYTES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    i2c_mts_in_if.sink    i_in,
    i2c_mts_out_if.source o_out
);

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_out_item w_result;
    logic      w_advance;

    assign w_advance   = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || w_advance;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_item;

    i2c_mts_core #(
        .MAX_BYTES(MAX_BYTES)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_advance(w_advance),
        .i_item   (r_in_item),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // hold payloads until the next transaction moves in
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_item <= i_in.data;
        end
        if (w_advance) begin
            r_out_item <= w_result;
        end
    end

`ifndef ASSERT_OFF
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_in.ready)
        else $error("input stalled with an empty result register");

    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("processed transaction lost before result register");

    a_stop_completes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_item.send_stop |->
            (r_out_item.completion != CMP_BUSY) && r_out_item.clear_interrupt
            && !r_out_item.load_byte_valid)
        else $error("stop without completion");

    a_error_code_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_item.error_flag |-> r_out_item.error_status == 8'h00)
        else $error("error code held without error flag");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_item.accepted |->
            r_out_item.send_start && !r_out_item.error_flag)
        else $error("accepted start without start request");
`endif

endmodule

// File: dv/tb_i2c_master_transfer_sequencer.sv
`timescale 1ns / 100ps

module tb_i2c_master_transfer_sequencer;
    import i2c_mts_pkg::*;

    localparam int         WATCHDOG_LIMIT = 1000;
    localparam int         DRAIN_CYCLES   = 8;
    localparam int         PHASE_ITEMS    = 200;
    localparam logic [7:0] ST_UNLISTED    = 8'hFF;

    // Tracks the sequencer state and holds the results still owed by the block.
    class transfer_scoreboard;
        logic [7:0] slave_addr;
        logic [7:0] reg_first;
        logic       rd_mode;
        logic [2:0] xfer_count;
        logic [2:0] ptr;
        logic [7:0] rx_buf [MAX_BYTES_DEF];
        logic       err_seen;
        logic [7:0] err_code;
        t_out_item  expected_q [$];
        int         errors;

        function new();
            slave_addr = '0;
            reg_first  = '0;
            rd_mode    = 1'b0;
            xfer_count = '0;
            ptr        = '0;
            err_seen   = 1'b0;
            err_code   = '0;
            errors     = 0;
            foreach (rx_buf[i]) rx_buf[i] = '0;
        endfunction

        task report(string what);
            errors++;
            if (errors <= 50) $display("[%0t] mismatch: %s", $time, what);
        endtask

        function int pending();
            return expected_q.size();
        endfunction

        function void bump_ptr();
            if (ptr < 3'd7) ptr = ptr + 3'd1;
        endfunction

        function void store_rx(logic [7:0] b);
            if (ptr < MAX_BYTES_DEF) rx_buf[ptr] = b;
            bump_ptr();
        endfunction

        function void stop_req(inout t_out_item r);
            r.clear_start     = 1'b1;
            r.send_stop       = 1'b1;
            r.clear_interrupt = 1'b1;
            r.completion      = rd_mode ? CMP_READ : CMP_WRITE;
        endfunction

        function void load_tx(inout t_out_item r, input logic [7:0] b);
            r.load_byte_valid = 1'b1;
            r.transmit_byte   = b;
            r.clear_interrupt = 1'b1;
        endfunction

        function void record_err(logic [7:0] code);
            err_seen = 1'b1;
            err_code = code;
        endfunction

        function void note_transfer(t_in_item it);
            t_out_item  r;
            logic [7:0] b;
            r = '0;
            if (it.action == ACT_START) begin
                if (it.byte_count <= MAX_BYTES_DEF) begin
                    err_seen   = 1'b0;
                    err_code   = '0;
                    rd_mode    = it.read_mode;
                    slave_addr = it.device_address;
                    reg_first  = it.first_register;
                    xfer_count = it.byte_count;
                    if (!rd_mode) begin
                        for (int i = 0; i < MAX_BYTES_DEF; i++)
                            if (i < it.byte_count) rx_buf[i] = it.write_data[8*i +: 8];
                    end
                    r.accepted   = 1'b1;
                    r.send_start = 1'b1;
                end
            end else begin
                case (it.bus_status)
                    ST_START: begin
                        ptr = '0;
                        load_tx(r, slave_addr);
                    end
                    ST_RESTART: load_tx(r, slave_addr | READ_BIT);
                    ST_ADDR_ACK: begin
                        r.clear_start = 1'b1;
                        if (xfer_count == 0) stop_req(r);
                        else load_tx(r, reg_first);
                    end
                    ST_DATA_ACK: begin
                        if (rd_mode) begin
                            r.send_start      = 1'b1;
                            r.clear_interrupt = 1'b1;
                        end else if (ptr >= xfer_count) begin
                            stop_req(r);
                        end else begin
                            b = (ptr < MAX_BYTES_DEF) ? rx_buf[ptr] : 8'h00;
                            bump_ptr();
                            load_tx(r, b);
                        end
                    end
                    ST_RADDR_ACK: begin
                        r.clear_start     = 1'b1;
                        r.ack_control     = (xfer_count > 1) ? ACK_NEXT : NACK_NEXT;
                        r.clear_interrupt = 1'b1;
                    end
                    ST_RX_ACKED: begin
                        store_rx(it.received_byte);
                        r.ack_control = (int'(ptr) + 1 >= int'(xfer_count)) ? NACK_NEXT
                                                                            : ACK_NEXT;
                        r.clear_interrupt = 1'b1;
                    end
                    ST_RX_NACKED: begin
                        store_rx(it.received_byte);
                        stop_req(r);
                    end
                    ST_ARB_LOST: begin
                        record_err(it.bus_status);
                        ptr = '0;
                    end
                    default: begin
                        record_err(it.bus_status);
                        stop_req(r);
                    end
                endcase
            end
            r.error_flag   = err_seen;
            r.error_status = err_code;
            for (int i = 0; i < MAX_BYTES_DEF; i++) r.read_data[8*i +: 8] = rx_buf[i];
            expected_q.push_back(r);
        endfunction

        task cmp_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want) report($sformatf("%s got %0h, expected %0h", name, got, want));
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            if (expected_q.size() == 0) begin
                report("result transaction with nothing expected");
                return;
            end
            want = expected_q.pop_front();
            cmp_field("accepted", got.accepted, want.accepted);
            cmp_field("send_start", got.send_start, want.send_start);
            cmp_field("clear_start", got.clear_start, want.clear_start);
            cmp_field("send_stop", got.send_stop, want.send_stop);
            cmp_field("load_byte_valid", got.load_byte_valid, want.load_byte_valid);
            cmp_field("transmit_byte", got.transmit_byte, want.transmit_byte);
            cmp_field("ack_control", got.ack_control, want.ack_control);
            cmp_field("clear_interrupt", got.clear_interrupt, want.clear_interrupt);
            cmp_field("completion", got.completion, want.completion);
            cmp_field("error_flag", got.error_flag, want.error_flag);
            cmp_field("error_status", got.error_status, want.error_status);
            cmp_field("read_data", got.read_data, want.read_data);
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    i2c_mts_in_if  in_if ();
    i2c_mts_out_if out_if ();

    i2c_master_transfer_sequencer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    transfer_scoreboard sb;
    t_in_item           stim_q [$];
    int                 send_idle_pct  = 0;
    int                 recv_stall_pct = 0;
    int                 idle_cycles    = 0;

    always #5 i_clk = ~i_clk;

    // Start items carry noise in the event fields and the other way round.
    function t_in_item make_start(logic rd, logic [7:0] addr, logic [7:0] regno,
                                  logic [2:0] cnt, logic [31:0] wd);
        t_in_item it;
        it.action         = ACT_START;
        it.read_mode      = rd;
        it.device_address = addr;
        it.first_register = regno;
        it.byte_count     = cnt;
        it.write_data     = wd;
        it.bus_status     = 8'($urandom);
        it.received_byte  = 8'($urandom);
        return it;
    endfunction

    function t_in_item make_event(logic [7:0] status, logic [7:0] rx);
        t_in_item it;
        it.action         = ACT_EVENT;
        it.read_mode      = 1'($urandom);
        it.device_address = 8'($urandom);
        it.first_register = 8'($urandom);
        it.byte_count     = 3'($urandom);
        it.write_data     = $urandom;
        it.bus_status     = status;
        it.received_byte  = rx;
        return it;
    endfunction

    // Build one register transfer, now and then broken off by an error or
    // salted with a stray status event.
    function void queue_transfer();
        t_in_item   seq [$];
        logic       rd;
        int         cnt;
        int         extra;
        int         cut;
        logic [7:0] bad;
        rd    = 1'($urandom_range(0, 1));
        cnt   = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
        extra = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 6) : 0;
        seq.push_back(make_start(rd, 8'($urandom), 8'($urandom), 3'(cnt), $urandom));
        seq.push_back(make_event(ST_START, 8'($urandom)));
        seq.push_back(make_event(ST_ADDR_ACK, 8'($urandom)));
        if (cnt != 0) begin
            if (!rd) begin
                for (int i = 0; i <= cnt; i++)
                    seq.push_back(make_event(ST_DATA_ACK, 8'($urandom)));
            end else begin
                seq.push_back(make_event(ST_DATA_ACK, 8'($urandom)));
                seq.push_back(make_event(ST_RESTART, 8'($urandom)));
                seq.push_back(make_event(ST_RADDR_ACK, 8'($urandom)));
                for (int i = 1; i < cnt + extra; i++)
                    seq.push_back(make_event(ST_RX_ACKED, 8'($urandom)));
                seq.push_back(make_event(ST_RX_NACKED, 8'($urandom)));
            end
        end
        if ($urandom_range(0, 4) == 0) begin
            cut = $urandom_range(1, seq.size() - 1);
            while (seq.size() > cut) seq.delete(seq.size() - 1);
            case ($urandom_range(0, 6))
                0: bad = ST_BUS_ERROR;
                1: bad = ST_ADDR_NACK;
                2: bad = ST_DATA_NACK;
                3: bad = ST_ARB_LOST;
                4: bad = ST_RADDR_NACK;
                5: bad = ST_RX_NACKED;
                default: bad = 8'($urandom_range(0, 255));
            endcase
            seq.push_back(make_event(bad, 8'($urandom)));
        end
        if ($urandom_range(0, 9) == 0)
            seq.insert($urandom_range(1, seq.size()),
                       make_event(8'($urandom_range(0, 255)), 8'($urandom)));
        foreach (seq[i]) stim_q.push_back(seq[i]);
    endfunction

    task drive_item(t_in_item it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= it;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task drive_queue();
        while (stim_q.size() != 0) drive_item(stim_q.pop_front());
        in_if.valid <= 1'b0;
    endtask

    // Hold off the sender until every outstanding result has been taken.
    task drain();
        while (sb.pending() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) sb.note_transfer(in_if.data);
            if (out_if.valid && out_if.ready) sb.check_result(out_if.data);
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("** i2c_master_transfer_sequencer: FAILED **");
            $finish;
        end
    end

    initial begin
        sb          = new();
        i_rst_n     = 1'b0;
        in_if.valid = 1'b0;
        in_if.data  = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // write of four bytes at the extremes of address, register and data
        stim_q.push_back(make_start(1'b0, 8'hFE, 8'hFF, 3'd4, 32'hFFFF_FFFF));
        stim_q.push_back(make_event(ST_START, 8'h00));
        stim_q.push_back(make_event(ST_ADDR_ACK, 8'hFF));
        repeat (5) stim_q.push_back(make_event(ST_DATA_ACK, 8'h00));
        // two-byte read with repeated start
        stim_q.push_back(make_start(1'b1, 8'h00, 8'h00, 3'd2, 32'h0000_0000));
        stim_q.push_back(make_event(ST_START, 8'h00));
        stim_q.push_back(make_event(ST_ADDR_ACK, 8'h00));
        stim_q.push_back(make_event(ST_DATA_ACK, 8'h00));
        stim_q.push_back(make_event(ST_RESTART, 8'h00));
        stim_q.push_back(make_event(ST_RADDR_ACK, 8'h00));
        stim_q.push_back(make_event(ST_RX_ACKED, 8'hFF));
        stim_q.push_back(make_event(ST_RX_NACKED, 8'h00));
        // oversized counts are refused
        stim_q.push_back(make_start(1'b0, 8'h12, 8'h34, 3'd7, 32'h1234_5678));
        stim_q.push_back(make_start(1'b1, 8'h56, 8'h78, 3'd5, 32'h9ABC_DEF0));
        // zero-byte read: NACK at once, then stop after the address
        stim_q.push_back(make_start(1'b1, 8'hFF, 8'h5A, 3'd0, 32'hA5A5_5A5A));
        stim_q.push_back(make_event(ST_RADDR_ACK, 8'h00));
        stim_q.push_back(make_event(ST_RX_ACKED, 8'hA5));
        stim_q.push_back(make_event(ST_ADDR_ACK, 8'h00));
        // arbitration loss, bus error, NACKs and an unknown status
        stim_q.push_back(make_event(ST_ARB_LOST, 8'h00));
        stim_q.push_back(make_event(ST_BUS_ERROR, 8'h00));
        stim_q.push_back(make_event(ST_ADDR_NACK, 8'h00));
        stim_q.push_back(make_event(ST_DATA_NACK, 8'h00));
        stim_q.push_back(make_event(ST_RADDR_NACK, 8'h00));
        stim_q.push_back(make_event(ST_UNLISTED, 8'h00));
        drive_queue();
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            while (stim_q.size() < PHASE_ITEMS) queue_transfer();
            drive_queue();
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("** i2c_master_transfer_sequencer: PASSED **");
        else
            $display("** i2c_master_transfer_sequencer: FAILED **");
        $finish;
    end

endmodule

// File: i2c_master_transfer_sequencer.f
rtl/i2c_mts_pkg.sv
rtl/i2c_mts_if.sv
rtl/i2c_mts_core.sv
rtl/i2c_master_transfer_sequencer.sv
dv/tb_i2c_master_transfer_sequencer.sv
